// ===== rtl/scalar_kalman_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter assertion macros
// Shared concurrent assertion forms for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scalar_kalman_filter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scalar_kalman_filter assertion failed");

`endif

// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Widths, register indexes, sequencer states and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  localparam int Q_RESET_INT = 10;
  localparam int R_RESET_INT = 400;

  localparam int DIV_STEPS = GAIN_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int MUL_A_W = DATA_W + 2;
  localparam int MUL_B_W = GAIN_W + 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [GAIN_W-1:0] gain_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DENOM,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_COV,
    ST_FINISH
  } skf_state_e;

endpackage

`default_nettype wire

// ===== rtl/skf_sample_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one signed sensor sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_sample_if;
  import skf_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/skf_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the filtered estimate and the gain used.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_result_if;
  import skf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;
  logic [GAIN_W-1:0]        gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

// ===== rtl/skf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_cfg_if;
  import skf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// Gain divider
// Radix-2 restoring divider producing floor(p * 2^16 / d), saturated to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [skf_pkg::DATA_W-1:0]    dividend_i,
  input  wire [skf_pkg::DATA_W:0]      divisor_i,
  output logic                         done_o,
  output logic [skf_pkg::GAIN_W-1:0]   quot_o
);
  import skf_pkg::*;

  logic [DATA_W:0]    div_q;
  logic [DATA_W+1:0]  rem_q, rem_d;
  logic [GAIN_W:0]    quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               zero_q;
  logic               done_q, done_d;
  logic [DATA_W+1:0]  trial;
  logic [DATA_W+1:0]  trial_sub;
  logic               fits;

  // The first step compares the unshifted dividend, so the top quotient bit can be set.
  always_comb begin
    trial     = (cnt_q == DIV_CNT_W'(DIV_STEPS)) ? rem_q : {rem_q[DATA_W:0], 1'b0};
    fits      = trial >= {1'b0, div_q};
    trial_sub = trial - {1'b0, div_q};
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {2'b00, dividend_i};
      quo_d  = '0;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub : trial;
      quo_d = {quo_q[GAIN_W-1:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : (quo_q[GAIN_W] ? '1 : quo_q[GAIN_W-1:0]);

endmodule

`default_nettype wire

// ===== rtl/skf_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, used for both filter products.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul (
  input  wire                               clk_i,
  input  wire                               en_i,
  input  wire signed [skf_pkg::MUL_A_W-1:0] a_i,
  input  wire signed [skf_pkg::MUL_B_W-1:0] b_i,
  output logic signed [skf_pkg::MUL_P_W-1:0] p_o
);
  import skf_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// First-order Kalman filter in fixed point with a divider and a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on sample_i, one signed Q16.16 word each. Every sample runs
// one predict/correct step and yields one word on result_o with the new
// estimate and the Q0.16 gain applied. The noise covariances Q and R are
// written through cfg_i (index 0 for Q, 1 for R); the user must write them
// only while the filter is idle, which the block itself does not enforce.
// Writes to other indexes are dropped. A sample is accepted only when the
// sequencer is idle. The result enters the output register and ready returns
// in the same cycle, so the filter takes a new sample only once it is through
// with the last one. The 17-step restoring divider for the gain takes most of
// the time per sample; the two multiplies share one registered multiplier.
// Reset clears the estimate and covariance and loads Q = 10.0 and R = 400.0.
// The result sits in an output register; while the receiver stalls the next
// sample is still accepted and processed, and the sequencer holds its finished
// result until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  skf_sample_if.sink   sample_i,
  skf_result_if.source result_o,
  skf_cfg_if.sink      cfg_i
);
  import skf_pkg::*;

  localparam logic [63:0] QWide   = 64'(Q_RESET_INT) << FRAC_BITS;
  localparam logic [63:0] RWide   = 64'(R_RESET_INT) << FRAC_BITS;
  localparam word_t       QReset  = (QWide > 64'hFFFF_FFFF) ? '1 : QWide[DATA_W-1:0];
  localparam word_t       RReset  = (RWide > 64'hFFFF_FFFF) ? '1 : RWide[DATA_W-1:0];
  localparam logic [GAIN_W:0] GainOne = {1'b1, {GAIN_W{1'b0}}};
  localparam logic signed [MUL_P_W-1:0] RoundHalf = MUL_P_W'(1) <<< (GAIN_W - 1);

  skf_state_e state_q, state_d;

  word_t              q_noise_q, r_noise_q;
  logic signed [DATA_W-1:0] last_est_q;
  word_t              cov_q;
  logic signed [DATA_W-1:0] z_q;
  word_t              p_mid_q;
  logic signed [DATA_W:0]   diff_q;
  gain_t              gain_q;
  logic signed [DATA_W+1:0] corr_q;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_est_q;
  gain_t                    out_gain_q;

  logic in_accept, out_free, fin_load, div_start, mul_en, sel_cov;
  logic [DATA_W:0]            pred_sum, denom;
  word_t                      p_mid_sat;
  logic                       div_done;
  gain_t                      div_quot;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p, mul_rnd;
  logic [GAIN_W:0]            one_minus_gain;
  logic signed [DATA_W+2:0]   est_sum;
  logic signed [DATA_W-1:0]   est_new;
  word_t                      cov_new;

  assign in_accept = sample_i.valid && sample_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_accept) state_d = ST_PRED;
      ST_PRED:    state_d = ST_DENOM;
      ST_DENOM:   state_d = ST_DIV;
      ST_DIV:     if (div_done) state_d = ST_MUL_EST;
      ST_MUL_EST: state_d = ST_MUL_COV;
      ST_MUL_COV: state_d = ST_FINISH;
      ST_FINISH:  if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready = 1'b0;
    div_start      = 1'b0;
    mul_en         = 1'b0;
    sel_cov        = 1'b0;
    fin_load       = 1'b0;
    case (state_q)
      ST_IDLE:    sample_i.ready = 1'b1;
      ST_DENOM:   div_start = 1'b1;
      ST_MUL_EST: mul_en = 1'b1;
      ST_MUL_COV: begin
        mul_en  = 1'b1;
        sel_cov = 1'b1;
      end
      ST_FINISH:  fin_load = out_free;
      default:    ;
    endcase
  end

  assign pred_sum  = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign p_mid_sat = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
  assign denom     = {1'b0, p_mid_q} + {1'b0, r_noise_q};

  skf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (p_mid_q),
    .divisor_i  (denom),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign one_minus_gain = GainOne - {1'b0, gain_q};
  assign mul_a = sel_cov ? $signed({2'b00, p_mid_q}) : $signed({diff_q[DATA_W], diff_q});
  assign mul_b = sel_cov ? $signed({1'b0, one_minus_gain}) : $signed({2'b00, gain_q});

  skf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign mul_rnd = mul_p + RoundHalf;

  always_comb begin
    est_sum = $signed({{3{last_est_q[DATA_W-1]}}, last_est_q})
            + $signed({corr_q[DATA_W+1], corr_q});
    if (est_sum[DATA_W+2:DATA_W-1] != '0 && est_sum[DATA_W+2:DATA_W-1] != '1) begin
      est_new = est_sum[DATA_W+2] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      est_new = est_sum[DATA_W-1:0];
    end
    if (mul_rnd[MUL_P_W-1:DATA_W+GAIN_W] != '0) begin
      cov_new = '1;
    end else begin
      cov_new = mul_rnd[DATA_W+GAIN_W-1:GAIN_W];
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q_noise_q   <= QReset;
      r_noise_q   <= RReset;
      last_est_q  <= '0;
      cov_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_PROCESS_NOISE:     q_noise_q <= cfg_i.data;
          CFG_MEASUREMENT_NOISE: r_noise_q <= cfg_i.data;
          default:               ;
        endcase
      end
      if (fin_load) begin
        last_est_q  <= est_new;
        cov_q       <= cov_new;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      z_q <= sample_i.sample;
    end
    if (state_q == ST_PRED) begin
      p_mid_q <= p_mid_sat;
    end
    if (state_q == ST_DENOM) begin
      diff_q <= $signed({z_q[DATA_W-1], z_q}) - $signed({last_est_q[DATA_W-1], last_est_q});
    end
    if (state_q == ST_DIV && div_done) begin
      gain_q <= div_quot;
    end
    if (state_q == ST_MUL_COV) begin
      corr_q <= mul_rnd[DATA_W+GAIN_W+1:GAIN_W];
    end
    if (fin_load) begin
      out_est_q  <= est_new;
      out_gain_q <= gain_q;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.estimate = out_est_q;
  assign result_o.gain     = out_gain_q;

endmodule

`default_nettype wire

// ===== rtl/skf_checker.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter checker
// Port-level assertions on the filter's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scalar_kalman_filter_macros.svh"

module skf_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_ready_i,
  input wire                             out_valid_i,
  input wire                             out_ready_i,
  input wire [skf_pkg::DATA_W-1:0]       out_estimate_i,
  input wire [skf_pkg::GAIN_W-1:0]       out_gain_i,
  input wire                             cfg_ready_i
);
  import skf_pkg::*;

  logic in_accept;
  assign in_accept = in_valid_i && in_ready_i;

  `SKF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_estimate_i) && $stable(out_gain_i))
  `SKF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_accept, !in_ready_i)
  `SKF_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_accept, !$rose(out_valid_i))
  `SKF_ASSERT_IMP(a_cfg_always_ready, clk_i, rst_ni, 1'b1, cfg_ready_i)

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_estimate_i (result_o.estimate),
  .out_gain_i     (result_o.gain),
  .cfg_ready_i    (cfg_i.ready)
);

`default_nettype wire
